@@ hw/rtl/multistep_attack_host_tracker_core_macros.svh @@
// Assertion macros for the multistep attack host tracker checker.
// Depends on nothing; included by the checker file.
`ifndef MULTISTEP_ATTACK_HOST_TRACKER_CORE_MACROS_SVH
`define MULTISTEP_ATTACK_HOST_TRACKER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define MAHT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is low
`define MAHT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ hw/rtl/mahtrk_pkg.sv @@
// Shared types and constants of the multistep attack host tracker.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none
package mahtrk_pkg;

  // Arrival port codes
  localparam logic [1:0] PORT_HTTP = 2'd0;
  localparam logic [1:0] PORT_FTP  = 2'd1;
  localparam logic [1:0] PORT_SSH  = 2'd2;
  localparam logic [1:0] PORT_BAD  = 2'd3;

  // Action codes
  localparam logic ACT_PACKET = 1'b0;
  localparam logic ACT_SWEEP  = 1'b1;

  // TCP port rules
  localparam logic [15:0] TCP_HTTP_SRC = 16'd80;
  localparam logic [15:0] TCP_FTP_DST  = 16'd20;
  localparam logic [15:0] TCP_SSH_SRC  = 16'd22;

  // Attack stages
  localparam logic [1:0] STAGE_NONE = 2'd0;
  localparam logic [1:0] STAGE_SSH  = 2'd1;
  localparam logic [1:0] STAGE_HTTP = 2'd2;
  localparam logic [1:0] STAGE_FTP  = 2'd3;

  // Register map (word index taken from paddr[2])
  localparam logic REG_EXPIRE = 1'b0;
  localparam logic [31:0] EXPIRE_RESET = 32'd60;

  localparam logic [6:0] CNT_MAX = 7'd127;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SWEEP
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic lookup;
    logic sweep;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic sweep_done;
  } sts_t;

endpackage
`default_nettype wire

@@ hw/rtl/mahtrk_ctrl.sv @@
// Controller state machine of the host tracker: accept, lookup, sweep walk.
// Depends on mahtrk_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mahtrk_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 start,
  input  wire                 action_i,
  input  mahtrk_pkg::sts_t    sts_i,
  output mahtrk_pkg::cmd_t    cmd_o,
  output logic                busy
);
  import mahtrk_pkg::*;

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.load = 1'b1;
          state_d = (action_i == ACT_SWEEP) ? ST_SWEEP : ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd_o.lookup = 1'b1;
        state_d = ST_IDLE;
      end
      ST_SWEEP: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_done) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ hw/rtl/mahtrk_dp.sv @@
// Datapath of the host tracker: host table, parallel key match, sweep walk, result.
// Depends on mahtrk_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mahtrk_dp #(
  parameter int TABLE_ENTRIES = 64
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  mahtrk_pkg::cmd_t    cmd_i,
  output mahtrk_pkg::sts_t    sts_o,
  input  wire  [31:0]         expire_i,
  input  wire                 action_i,
  input  wire  [1:0]          arrival_port_i,
  input  wire  [31:0]         src_ip_i,
  input  wire  [31:0]         dst_ip_i,
  input  wire  [15:0]         src_tcp_port_i,
  input  wire  [15:0]         dst_tcp_port_i,
  input  wire  [31:0]         now_seconds_i,
  output logic                result_valid_o,
  output logic [1:0]          out_port_o,
  output logic                forwarded_o,
  output logic                tagged_res_o,
  output logic                not_stored_o,
  output logic [6:0]          removed_count_o
);
  import mahtrk_pkg::*;

  localparam int IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_ENTRIES - 1);

  // Table storage
  logic              valid_q   [TABLE_ENTRIES];
  logic [31:0]       host_q    [TABLE_ENTRIES];
  logic [1:0]        stage_q   [TABLE_ENTRIES];
  logic [31:0]       created_mem [TABLE_ENTRIES];

  // Latched item
  logic [1:0]  port_q;
  logic        ok_q;
  logic [31:0] key_q;
  logic [1:0]  cand_q;
  logic [31:0] now_q;
  logic [31:0] limit_q;

  // Sweep walk
  logic [IdxW-1:0] idx_q;
  logic            issue_q;
  logic [31:0]     rd_q;
  logic [IdxW-1:0] chk_idx_q;
  logic            chk_vld_q;
  logic [6:0]      cnt_q;

  // Result registers
  logic       res_vld_q;
  logic [1:0] res_port_q;
  logic       res_fwd_q, res_tag_q, res_nst_q;
  logic [6:0] res_cnt_q;

  // Rule decode at accept
  logic        ok_d;
  logic [31:0] key_d;
  logic [1:0]  cand_d;
  always_comb begin
    ok_d   = 1'b0;
    key_d  = src_ip_i;
    cand_d = STAGE_NONE;
    case (arrival_port_i)
      PORT_HTTP: begin
        ok_d = (src_tcp_port_i == TCP_HTTP_SRC);
        key_d = dst_ip_i;
        cand_d = STAGE_HTTP;
      end
      PORT_FTP: begin
        ok_d = (dst_tcp_port_i == TCP_FTP_DST);
        cand_d = STAGE_FTP;
      end
      PORT_SSH: begin
        ok_d = (src_tcp_port_i == TCP_SSH_SRC);
        cand_d = STAGE_SSH;
      end
      default: begin
        ok_d = 1'b0;
      end
    endcase
  end

  // Latch the item
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      port_q  <= arrival_port_i;
      ok_q    <= ok_d;
      key_q   <= key_d;
      cand_q  <= cand_d;
      now_q   <= now_seconds_i;
      limit_q <= now_seconds_i - expire_i;
    end
  end

  // Parallel key match and first free slot
  logic            hit_any, free_any;
  logic [IdxW-1:0] hit_idx, free_idx;
  always_comb begin
    hit_any  = 1'b0;
    free_any = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (valid_q[i] && host_q[i] == key_q) begin
        hit_any = 1'b1;
        hit_idx = IdxW'(i);
      end
      if (!valid_q[i]) begin
        free_any = 1'b1;
        free_idx = IdxW'(i);
      end
    end
  end

  // Lookup decision
  logic [2:0] next_stage;
  logic       lk_tag, lk_nst, lk_fwd, lk_create, lk_adv;
  logic [1:0] lk_port;
  always_comb begin
    next_stage = {1'b0, stage_q[hit_idx]} + 3'd1;
    lk_tag    = 1'b0;
    lk_nst    = 1'b0;
    lk_fwd    = 1'b1;
    lk_create = 1'b0;
    lk_adv    = 1'b0;
    lk_port   = port_q;
    if (port_q == PORT_BAD) begin
      lk_fwd  = 1'b0;
      lk_port = PORT_HTTP;
    end else if (ok_q) begin
      if (hit_any) begin
        lk_tag = ({1'b0, cand_q} <= next_stage);
        lk_adv = ({1'b0, cand_q} == next_stage);
      end else if (cand_q == STAGE_SSH) begin
        lk_tag = 1'b1;
        if (free_any) begin
          lk_create = 1'b1;
        end else begin
          lk_nst = 1'b1;
        end
      end
    end
  end

  // Sweep compare
  logic       rm;
  logic [6:0] cnt_d;
  assign rm    = chk_vld_q && valid_q[chk_idx_q] && (rd_q < limit_q);
  assign cnt_d = (rm && cnt_q != CNT_MAX) ? cnt_q + 7'd1 : cnt_q;
  assign sts_o.sweep_done = chk_vld_q && (chk_idx_q == LastIdx);

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        valid_q[i] <= 1'b0;
      end
    end else if (cmd_i.lookup && lk_create) begin
      valid_q[free_idx] <= 1'b1;
    end else if (cmd_i.sweep && rm) begin
      valid_q[chk_idx_q] <= 1'b0;
    end
  end

  // Host and stage write back
  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup && lk_create) begin
      host_q[free_idx]  <= key_q;
      stage_q[free_idx] <= STAGE_SSH;
    end else if (cmd_i.lookup && lk_adv) begin
      stage_q[hit_idx] <= cand_q;
    end
  end

  // Creation time memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup && lk_create) begin
      created_mem[free_idx] <= now_q;
    end
    rd_q <= created_mem[idx_q];
  end

  // Advance the sweep walk
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      issue_q   <= 1'b0;
      chk_vld_q <= 1'b0;
      chk_idx_q <= '0;
      cnt_q     <= '0;
    end else if (cmd_i.load) begin
      idx_q     <= '0;
      issue_q   <= (action_i == ACT_SWEEP);
      chk_vld_q <= 1'b0;
      cnt_q     <= '0;
    end else if (cmd_i.sweep) begin
      cnt_q     <= cnt_d;
      chk_vld_q <= issue_q;
      chk_idx_q <= idx_q;
      if (issue_q) begin
        if (idx_q == LastIdx) begin
          issue_q <= 1'b0;
        end else begin
          idx_q <= idx_q + 1'b1;
        end
      end
    end
  end

  // Result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= cmd_i.lookup || (cmd_i.sweep && sts_o.sweep_done);
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      res_port_q <= lk_port;
      res_fwd_q  <= lk_fwd;
      res_tag_q  <= lk_tag;
      res_nst_q  <= lk_nst;
      res_cnt_q  <= '0;
    end else if (cmd_i.sweep && sts_o.sweep_done) begin
      res_port_q <= PORT_HTTP;
      res_fwd_q  <= 1'b0;
      res_tag_q  <= 1'b0;
      res_nst_q  <= 1'b0;
      res_cnt_q  <= cnt_d;
    end
  end

  assign result_valid_o  = res_vld_q;
  assign out_port_o      = res_port_q;
  assign forwarded_o     = res_fwd_q;
  assign tagged_res_o    = res_tag_q;
  assign not_stored_o    = res_nst_q;
  assign removed_count_o = res_cnt_q;

endmodule
`default_nettype wire

@@ hw/rtl/multistep_attack_host_tracker_core.sv @@
// Top level of the multistep attack host tracker: config register, controller, datapath.
// Depends on mahtrk_pkg, mahtrk_ctrl and mahtrk_dp.
//
// Usage:
//   Drive an item on the input ports and raise start; it is taken at a rising
//   edge where start is high and busy is low. busy stays high while the item
//   is processed.
//   A packet item is latched, with its port rule decoded, when it is taken;
//   the parallel host match over all table entries and the write back follow.
//   Its result shows on the result ports, marked by result_valid_o, in the
//   cycle after that, while the next item can already be taken.
//   A sweep item walks the creation time memory one entry a cycle, through
//   its single read port.
//   Each result is held for exactly one cycle; the receiver cannot stall.
//   Reset clears all table entries and sets expire_seconds to 60.
//   expire_seconds sits at byte address 0 of the APB port; write it only
//   while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
module multistep_attack_host_tracker_core #(
  parameter int TABLE_ENTRIES = 64
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // configuration
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // item
  input  wire         start,
  output logic        busy,
  input  wire         action_i,
  input  wire  [1:0]  arrival_port_i,
  input  wire  [31:0] src_ip_i,
  input  wire  [31:0] dst_ip_i,
  input  wire  [15:0] src_tcp_port_i,
  input  wire  [15:0] dst_tcp_port_i,
  input  wire  [31:0] now_seconds_i,
  // result
  output logic        result_valid_o,
  output logic [1:0]  out_port_o,
  output logic        forwarded_o,
  output logic        tagged_res_o,
  output logic        not_stored_o,
  output logic [6:0]  removed_count_o
);
  import mahtrk_pkg::*;

  logic [31:0] expire_q;
  cmd_t        cmd;
  sts_t        sts;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expire_q <= EXPIRE_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_EXPIRE) begin
      expire_q <= pwdata;
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_EXPIRE) ? expire_q : '0;

  mahtrk_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .action_i (action_i),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  mahtrk_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .expire_i        (expire_q),
    .action_i        (action_i),
    .arrival_port_i  (arrival_port_i),
    .src_ip_i        (src_ip_i),
    .dst_ip_i        (dst_ip_i),
    .src_tcp_port_i  (src_tcp_port_i),
    .dst_tcp_port_i  (dst_tcp_port_i),
    .now_seconds_i   (now_seconds_i),
    .result_valid_o  (result_valid_o),
    .out_port_o      (out_port_o),
    .forwarded_o     (forwarded_o),
    .tagged_res_o    (tagged_res_o),
    .not_stored_o    (not_stored_o),
    .removed_count_o (removed_count_o)
  );

endmodule
`default_nettype wire

@@ hw/rtl/mahtrk_chk.sv @@
// Port-level checker of the host tracker, bound to the top level.
// Depends on multistep_attack_host_tracker_core_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "multistep_attack_host_tracker_core_macros.svh"
module mahtrk_chk (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       start,
  input wire       busy,
  input wire       action_i,
  input wire       result_valid_o,
  input wire       forwarded_o,
  input wire       tagged_res_o,
  input wire       not_stored_o,
  input wire [6:0] removed_count_o
);

  // Accepted item raises busy
  `MAHT_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy)

  // Packet result follows accept through the lookup state
  `MAHT_ASSERT_NEXT(a_pkt_latency, clk_i, rst_ni, start && !busy && !action_i, ##1 result_valid_o)

  // Result shows only while idle
  `MAHT_ASSERT_SAME(a_res_idle, clk_i, rst_ni, result_valid_o, !busy)

  // Untagged unless forwarded; not_stored always comes with a tag
  `MAHT_ASSERT_SAME(a_tag_fwd, clk_i, rst_ni, result_valid_o && (tagged_res_o || not_stored_o), forwarded_o && tagged_res_o)

  // Removals come only from sweeps
  `MAHT_ASSERT_SAME(a_cnt_sweep, clk_i, rst_ni, result_valid_o && removed_count_o != 7'd0, !forwarded_o)

endmodule

bind multistep_attack_host_tracker_core mahtrk_chk u_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .action_i        (action_i),
  .result_valid_o  (result_valid_o),
  .forwarded_o     (forwarded_o),
  .tagged_res_o    (tagged_res_o),
  .not_stored_o    (not_stored_o),
  .removed_count_o (removed_count_o)
);
`default_nettype wire

@@ tb/multistep_attack_host_tracker_checker.sv @@
// Checker for the multistep attack host tracker: predicts each result and compares it.
// Depends on mahtrk_pkg; watches the APB port, the item port and the result port.
`timescale 1ns / 1ps
module multistep_attack_host_tracker_checker
  import mahtrk_pkg::*;
#(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        start,
  input  logic        busy,
  input  logic        action_i,
  input  logic [1:0]  arrival_port_i,
  input  logic [31:0] src_ip_i,
  input  logic [31:0] dst_ip_i,
  input  logic [15:0] src_tcp_port_i,
  input  logic [15:0] dst_tcp_port_i,
  input  logic [31:0] now_seconds_i,
  input  logic        result_valid_o,
  input  logic [1:0]  out_port_o,
  input  logic        forwarded_o,
  input  logic        tagged_res_o,
  input  logic        not_stored_o,
  input  logic [6:0]  removed_count_o,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [1:0] port;
    logic       fwd;
    logic       tag;
    logic       nst;
    logic [6:0] cnt;
  } verdict_t;

  verdict_t   verdicts_q[$];
  logic [31:0] expire_s;
  logic        host_valid[TABLE_ENTRIES];
  logic [31:0] host_addr[TABLE_ENTRIES];
  logic [1:0]  host_stage[TABLE_ENTRIES];
  logic [31:0] host_born[TABLE_ENTRIES];

  initial fail_count = 0;
  assign pending = verdicts_q.size();

  task automatic report(string what, int got, int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  // Work out the verdict of one item and update the host table.
  function automatic verdict_t track_item(logic act, logic [1:0] port, logic [31:0] sip,
                                          logic [31:0] dip, logic [15:0] sp,
                                          logic [15:0] dp, logic [31:0] now);
    verdict_t   v;
    logic [31:0] limit;
    logic [31:0] host;
    logic [1:0]  cand;
    int          hit;
    int          free_idx;
    v = '0;
    hit = -1;
    free_idx = -1;
    if (act == ACT_SWEEP) begin
      limit = now - expire_s;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (host_valid[i] && host_born[i] < limit) begin
          host_valid[i] = 1'b0;
          if (v.cnt != CNT_MAX) v.cnt++;
        end
      end
      return v;
    end
    // Drop bad ports, forward packets failing their rule untouched
    if (port == PORT_BAD) return v;
    v.port = port;
    v.fwd = 1'b1;
    case (port)
      PORT_HTTP: begin
        if (sp != TCP_HTTP_SRC) return v;
        host = dip;
        cand = STAGE_HTTP;
      end
      PORT_FTP: begin
        if (dp != TCP_FTP_DST) return v;
        host = sip;
        cand = STAGE_FTP;
      end
      default: begin
        if (sp != TCP_SSH_SRC) return v;
        host = sip;
        cand = STAGE_SSH;
      end
    endcase
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (host_valid[i]) begin
        if (hit < 0 && host_addr[i] == host) hit = i;
      end else if (free_idx < 0) begin
        free_idx = i;
      end
    end
    if (hit < 0) begin
      if (cand != STAGE_SSH) return v;
      // Full table: tag but keep nothing
      if (free_idx < 0) begin
        v.tag = 1'b1;
        v.nst = 1'b1;
        return v;
      end
      host_valid[free_idx] = 1'b1;
      host_addr[free_idx] = host;
      host_stage[free_idx] = STAGE_NONE;
      host_born[free_idx] = now;
      hit = free_idx;
    end
    if ({1'b0, cand} <= {1'b0, host_stage[hit]} + 3'd1) begin
      v.tag = 1'b1;
      if ({1'b0, cand} == {1'b0, host_stage[hit]} + 3'd1) host_stage[hit] = cand;
    end
    return v;
  endfunction

  // Track config writes, accepted items and results
  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t want;
    if (!rst_ni) begin
      expire_s <= EXPIRE_RESET;
      for (int i = 0; i < TABLE_ENTRIES; i++) host_valid[i] = 1'b0;
      verdicts_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == REG_EXPIRE) expire_s <= pwdata;
      if (start && !busy)
        verdicts_q.push_back(track_item(action_i, arrival_port_i, src_ip_i, dst_ip_i,
                                        src_tcp_port_i, dst_tcp_port_i, now_seconds_i));
      if (result_valid_o) begin
        if (verdicts_q.size() == 0) begin
          report("unexpected result", 1, 0);
        end else begin
          want = verdicts_q.pop_front();
          if (out_port_o !== want.port) report("out_port", out_port_o, want.port);
          if (forwarded_o !== want.fwd) report("forwarded", forwarded_o, want.fwd);
          if (tagged_res_o !== want.tag) report("tagged_res", tagged_res_o, want.tag);
          if (not_stored_o !== want.nst) report("not_stored", not_stored_o, want.nst);
          if (removed_count_o !== want.cnt)
            report("removed_count", removed_count_o, want.cnt);
        end
      end
    end
  end

endmodule

@@ tb/tb.sv @@
// Top of the host tracker testbench: clock, reset, stimulus and verdict.
// Depends on mahtrk_pkg, the tracker core and multistep_attack_host_tracker_checker.
`timescale 1ns / 1ps
module tb;
  import mahtrk_pkg::*;

  localparam int ENTRIES = 64;
  localparam int STALL_LIMIT = 4000;
  localparam int POOL = 100;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        start = 1'b0;
  logic        busy;
  logic        action_i = ACT_PACKET;
  logic [1:0]  arrival_port_i = PORT_HTTP;
  logic [31:0] src_ip_i = '0, dst_ip_i = '0, now_seconds_i = '0;
  logic [15:0] src_tcp_port_i = '0, dst_tcp_port_i = '0;
  logic        result_valid_o, forwarded_o, tagged_res_o, not_stored_o;
  logic [1:0]  out_port_o;
  logic [6:0]  removed_count_o;
  int          fail_count, pending, stall_cycles;
  logic [31:0] clock_s;
  logic [31:0] hosts[POOL];

  always #4 clk_i = ~clk_i;

  multistep_attack_host_tracker_core #(.TABLE_ENTRIES(ENTRIES)) dut (.*);
  multistep_attack_host_tracker_checker #(.TABLE_ENTRIES(ENTRIES)) chk (.*);

  // Abort when nothing moves for too long
  initial stall_cycles = 0;
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o || !rst_ni) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("** multistep_attack_host_tracker_core: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Present one item and hold it until taken; start stays high afterwards
  task automatic send(logic act, logic [1:0] port, logic [31:0] sip, logic [31:0] dip,
                      logic [15:0] sp, logic [15:0] dp, logic [31:0] now);
    action_i <= act;
    arrival_port_i <= port;
    src_ip_i <= sip;
    dst_ip_i <= dip;
    src_tcp_port_i <= sp;
    dst_tcp_port_i <= dp;
    now_seconds_i <= now;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (ENTRIES + 4) @(posedge clk_i);
  endtask

  // Write expire_seconds through a setup and an access phase; block must be idle
  task automatic set_expire(logic [31:0] value);
    drain();
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {REG_EXPIRE, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  // Send a well-formed attack step for a pool host, or noise now and then
  task automatic random_item();
    logic [31:0] h;
    logic [31:0] sip, dip;
    logic [15:0] sp, dp;
    int          pick;
    h = hosts[$urandom_range(0, POOL - 1)];
    sip = $urandom;
    dip = $urandom;
    sp = 16'($urandom);
    dp = 16'($urandom);
    clock_s = clock_s + $urandom_range(0, 3);
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      send(ACT_SWEEP, 2'($urandom), sip, dip, sp, dp,
           ($urandom_range(0, 3) == 0) ? $urandom : clock_s);
    end else if (pick < 13) begin
      send(ACT_PACKET, 2'($urandom), sip, dip, sp, dp, $urandom);
    end else begin
      case ($urandom_range(0, 2))
        0: send(ACT_PACKET, PORT_SSH, h, dip, TCP_SSH_SRC, dp, clock_s);
        1: send(ACT_PACKET, PORT_HTTP, sip, h, TCP_HTTP_SRC, dp, clock_s);
        default: send(ACT_PACKET, PORT_FTP, h, dip, sp, TCP_FTP_DST, clock_s);
      endcase
    end
  endtask

  initial begin
    logic [31:0] expiries[4];
    int          idle_pct[4];
    expiries = '{32'd0, 32'hFFFF_FFFF, 32'd60, 32'd400};
    idle_pct = '{10, 53, 0, 0};
    for (int i = 0; i < POOL; i++) hosts[i] = $urandom;
    hosts[0] = 32'h0;
    hosts[1] = 32'hFFFF_FFFF;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: each rule, stage order, invalid port, field extremes, sweep wrap
    send(ACT_PACKET, PORT_HTTP, 32'h1, 32'hA, TCP_HTTP_SRC, 16'h0, 32'd5);
    send(ACT_PACKET, PORT_FTP, 32'hA, 32'h1, 16'hFFFF, TCP_FTP_DST, 32'd5);
    send(ACT_PACKET, PORT_SSH, 32'hA, 32'h0, TCP_SSH_SRC, 16'hFFFF, 32'd10);
    send(ACT_PACKET, PORT_FTP, 32'hA, 32'h0, 16'h0, TCP_FTP_DST, 32'd11);
    send(ACT_PACKET, PORT_HTTP, 32'h0, 32'hA, TCP_HTTP_SRC, 16'h0, 32'd12);
    send(ACT_PACKET, PORT_HTTP, 32'h0, 32'hA, TCP_HTTP_SRC, 16'h0, 32'd12);
    send(ACT_PACKET, PORT_FTP, 32'hA, 32'h0, 16'h0, TCP_FTP_DST, 32'd13);
    send(ACT_PACKET, PORT_FTP, 32'hA, 32'h0, 16'h0, TCP_FTP_DST, 32'd13);
    send(ACT_PACKET, PORT_SSH, 32'hA, 32'h0, TCP_SSH_SRC, 16'h0, 32'd14);
    send(ACT_PACKET, PORT_HTTP, 32'h0, 32'h0, 16'd81, 16'h0, 32'd15);
    send(ACT_PACKET, PORT_FTP, 32'h0, 32'h0, 16'h0, 16'd21, 32'd15);
    send(ACT_PACKET, PORT_SSH, 32'h0, 32'h0, 16'd23, 16'h0, 32'd15);
    send(ACT_PACKET, PORT_BAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
         32'hFFFF_FFFF);
    send(ACT_PACKET, PORT_SSH, 32'hFFFF_FFFF, 32'h0, TCP_SSH_SRC, 16'h0, 32'hFFFF_FFF0);
    send(ACT_PACKET, PORT_SSH, 32'h0, 32'h0, TCP_SSH_SRC, 16'h0, 32'h0);
    send(ACT_SWEEP, PORT_BAD, 32'h0, 32'h0, 16'h0, 16'h0, 32'd40);
    send(ACT_SWEEP, PORT_HTTP, 32'h0, 32'h0, 16'h0, 16'h0, 32'd80);
    send(ACT_SWEEP, PORT_HTTP, 32'h0, 32'h0, 16'h0, 16'h0, 32'd20);
    send(ACT_SWEEP, PORT_HTTP, 32'h0, 32'h0, 16'h0, 16'h0, 32'hFFFF_FFFF);

    // Random phases, each with its own expiry; the first two also idle the sender
    clock_s = 32'hFFFF_FE00;
    for (int ph = 0; ph < 4; ph++) begin
      set_expire(expiries[ph]);
      if (ph == 3) expiries[3] = $urandom;
      for (int n = 0; n < 450; n++) begin
        random_item();
        if (n == 200) drain();
        if (idle_pct[ph] != 0 && $urandom_range(0, 99) < idle_pct[ph]) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk_i);
        end
      end
    end
    set_expire(expiries[3]);

    // Wait out the last results, then give the verdict
    while (pending != 0) @(posedge clk_i);
    repeat (ENTRIES + 8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("** multistep_attack_host_tracker_core: PASSED **");
    end else begin
      $display("** multistep_attack_host_tracker_core: FAILED **");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/mahtrk_pkg.sv
hw/rtl/mahtrk_ctrl.sv
hw/rtl/mahtrk_dp.sv
hw/rtl/multistep_attack_host_tracker_core.sv
hw/rtl/mahtrk_chk.sv
tb/multistep_attack_host_tracker_checker.sv
tb/tb.sv
